// ===== hdl/module_response_stream_parser_defines.svh =====
// Assertion macros used by the response stream parser RTL.
`ifndef MODULE_RESPONSE_STREAM_PARSER_DEFINES_SVH
`define MODULE_RESPONSE_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MSP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("response stream parser: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("response stream parser: next-cycle check failed");

`endif

// ===== hdl/msp_pkg.sv =====
// Types and constants of the response stream parser.
package msp_pkg;

   // Request kinds.
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_ARM  = 1'b1;

   // Pattern lengths and texts, first character in the top byte.
   localparam int START_LEN   = 3;
   localparam int PROMPT_LEN  = 4;
   localparam int OK_LEN      = 3;
   localparam int ERROR_LEN   = 4;
   localparam int RESTART_LEN = 6;
   localparam int JOIN_LEN    = 7;
   localparam int LEAVE_LEN   = 10;

   localparam logic [8*START_LEN-1:0]   START_SEQ   = 24'h010203;
   localparam logic [8*PROMPT_LEN-1:0]  PROMPT_TXT  = "CMD>";
   localparam logic [8*OK_LEN-1:0]      OK_TXT      = "AOK";
   localparam logic [8*ERROR_LEN-1:0]   ERROR_TXT   = {"Err", 8'h0A};
   localparam logic [8*RESTART_LEN-1:0] RESTART_TXT = "REBOOT";
   localparam logic [8*JOIN_LEN-1:0]    JOIN_TXT    = "CONNECT";
   localparam logic [8*LEAVE_LEN-1:0]   LEAVE_TXT   = "DISCONNECT";

   localparam logic [7:0] PERCENT_CHAR = 8'h25;

   // One request: a received byte or an arm command.
   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } msp_req_type;

   // One response, produced for every request.
   typedef struct packed {
      logic       cmd_prompt_seen;
      logic       aok_seen;
      logic       err_seen;
      logic       reboot_seen;
      logic       stream_open_seen;
      logic       link_up;
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       frame_done;
   } msp_rsp_type;

endpackage

// ===== hdl/msp_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per transfer.
interface msp_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== hdl/module_response_stream_parser.sv =====
// Top level of the response stream parser for a radio module UART stream.
//
// Usage: requests arrive on req_if (valid/ready). Each request is either a
// received UART byte (kind 0) or an arm command (kind 1) that enables the
// stream-open report at the next closing percent sign. Every request yields
// exactly one response on rsp_if carrying the text-match pulses, the link
// level, and, for bytes inside a binary frame (01 02 03, length, payload),
// the payload byte with its index and a last-byte flag.
// Pipeline: a request accepted on req_if passes through the input register,
// the combinational state update and the result register, which drives
// rsp_if (one input register, one result register).
// Throughput: one request per cycle while rsp_if takes every response; the
// state update between the input and result registers is combinational.
// Reset: synchronous, active high; clears all matcher, frame and link state
// and empties both registers.
// Stall: while the response is not taken the result register holds; the
// input register still takes one more request, then ready drops until the
// receiver takes the waiting response.
module module_response_stream_parser
   import msp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   msp_stream_if.sink          req_if,
   msp_stream_if.source        rsp_if
);

`include "module_response_stream_parser_defines.svh"

   // Input register.
   logic        req_valid_ff;
   msp_req_type req_data_ff;
   // Result register.
   logic        rsp_valid_ff;
   msp_rsp_type rsp_data_ff;
   msp_rsp_type rsp_data_in;

   // Parser state.
   logic       in_frame_ff, in_frame_in;
   logic       length_taken_ff, length_taken_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] payload_count_ff, payload_count_in;
   logic [7:0] last_byte_ff, last_byte_in;
   logic       in_special_ff, in_special_in;
   logic       stream_armed_ff, stream_armed_in;
   logic       connected_ff, connected_in;

   logic       advance;
   logic       fire;
   logic       is_byte;
   logic       is_pct;
   logic [7:0] data;
   logic       start_step, text_out_step, text_in_step;
   logic       start_hit, prompt_hit, ok_hit, error_hit;
   logic       restart_hit, join_hit, leave_hit;
   logic [7:0] count_next;

   // Handshake: the result register frees when empty or taken.
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !req_valid_ff || advance;
   assign fire         = req_valid_ff && advance;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   assign data    = req_data_ff.rx_byte;
   assign is_byte = (req_data_ff.kind == KIND_BYTE);
   assign is_pct  = (data == PERCENT_CHAR);

   // Matcher step enables: text bytes outside frames only.
   assign start_step    = fire && is_byte && !in_frame_ff;
   assign text_out_step = start_step && !is_pct && !in_special_ff;
   assign text_in_step  = start_step && !is_pct && in_special_ff;

   msp_matcher #(.PAT_LEN(START_LEN), .PATTERN(START_SEQ)) u_start (
      .clock(clock), .reset(reset), .step(start_step), .data(data), .hit(start_hit)
   );
   msp_matcher #(.PAT_LEN(PROMPT_LEN), .PATTERN(PROMPT_TXT)) u_prompt (
      .clock(clock), .reset(reset), .step(text_out_step), .data(data), .hit(prompt_hit)
   );
   msp_matcher #(.PAT_LEN(OK_LEN), .PATTERN(OK_TXT)) u_ok (
      .clock(clock), .reset(reset), .step(text_out_step), .data(data), .hit(ok_hit)
   );
   msp_matcher #(.PAT_LEN(ERROR_LEN), .PATTERN(ERROR_TXT)) u_error (
      .clock(clock), .reset(reset), .step(text_out_step), .data(data), .hit(error_hit)
   );
   msp_matcher #(.PAT_LEN(RESTART_LEN), .PATTERN(RESTART_TXT)) u_restart (
      .clock(clock), .reset(reset), .step(text_in_step), .data(data), .hit(restart_hit)
   );
   msp_matcher #(.PAT_LEN(JOIN_LEN), .PATTERN(JOIN_TXT)) u_join (
      .clock(clock), .reset(reset), .step(text_in_step), .data(data), .hit(join_hit)
   );
   msp_matcher #(.PAT_LEN(LEAVE_LEN), .PATTERN(LEAVE_TXT)) u_leave (
      .clock(clock), .reset(reset), .step(text_in_step), .data(data), .hit(leave_hit)
   );

   assign count_next = payload_count_ff + 8'd1;

   // Per-request state update and response assembly.
   always_comb begin
      in_frame_in      = in_frame_ff;
      length_taken_in  = length_taken_ff;
      frame_length_in  = frame_length_ff;
      payload_count_in = payload_count_ff;
      last_byte_in     = last_byte_ff;
      in_special_in    = in_special_ff;
      stream_armed_in  = stream_armed_ff;
      connected_in     = connected_ff;
      rsp_data_in      = '0;
      if (fire) begin
         if (!is_byte) begin
            stream_armed_in = 1'b1;
         end else if (in_frame_ff) begin
            // Length byte, then payload bytes streamed with their index.
            if (!length_taken_ff) begin
               payload_count_in = '0;
               frame_length_in  = data;
               length_taken_in  = 1'b1;
            end else begin
               payload_count_in          = count_next;
               rsp_data_in.payload_valid = 1'b1;
               rsp_data_in.payload_byte  = data;
               rsp_data_in.payload_index = payload_count_ff;
               if (count_next == frame_length_ff) begin
                  in_frame_in            = 1'b0;
                  rsp_data_in.frame_done = 1'b1;
               end
            end
            last_byte_in = data;
         end else begin
            // Frame start sequence completing.
            if (start_hit) begin
               in_frame_in      = 1'b1;
               length_taken_in  = 1'b0;
               payload_count_in = '0;
            end
            // Percent handling: a percent opens or closes the region; double percent forces it on.
            if (is_pct) begin
               if (last_byte_ff == PERCENT_CHAR || !in_special_ff) begin
                  in_special_in = 1'b1;
               end else begin
                  in_special_in = 1'b0;
                  if (stream_armed_ff) begin
                     stream_armed_in              = 1'b0;
                     rsp_data_in.stream_open_seen = 1'b1;
                  end
               end
            end
            rsp_data_in.cmd_prompt_seen = prompt_hit;
            rsp_data_in.aok_seen        = ok_hit;
            rsp_data_in.err_seen        = error_hit;
            rsp_data_in.reboot_seen     = restart_hit;
            // DISCONNECT wins over CONNECT on the same byte.
            if (leave_hit) begin
               connected_in = 1'b0;
            end else if (join_hit) begin
               connected_in = 1'b1;
            end
            last_byte_in = data;
         end
      end
      rsp_data_in.link_up = connected_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         in_frame_ff      <= 1'b0;
         length_taken_ff  <= 1'b0;
         frame_length_ff  <= '0;
         payload_count_ff <= '0;
         last_byte_ff     <= '0;
         in_special_ff    <= 1'b0;
         stream_armed_ff  <= 1'b0;
         connected_ff     <= 1'b0;
      end else begin
         if (req_if.ready) begin
            req_valid_ff <= req_if.valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         in_frame_ff      <= in_frame_in;
         length_taken_ff  <= length_taken_in;
         frame_length_ff  <= frame_length_in;
         payload_count_ff <= payload_count_in;
         last_byte_ff     <= last_byte_in;
         in_special_ff    <= in_special_in;
         stream_armed_ff  <= stream_armed_in;
         connected_ff     <= connected_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         req_data_ff <= req_if.payload;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A payload response never carries a text-match pulse.
   `MSP_ASSERT_SAME(a_payload_no_text, clock, reset,
      rsp_valid_ff && rsp_data_ff.payload_valid,
      !(rsp_data_ff.cmd_prompt_seen || rsp_data_ff.aok_seen || rsp_data_ff.err_seen ||
        rsp_data_ff.reboot_seen || rsp_data_ff.stream_open_seen))
   // The last-byte flag only marks payload bytes.
   `MSP_ASSERT_SAME(a_done_has_payload, clock, reset,
      rsp_valid_ff && rsp_data_ff.frame_done, rsp_data_ff.payload_valid)
   // A byte after the length byte of an open frame yields a payload response.
   `MSP_ASSERT_NEXT(a_frame_byte_payload, clock, reset,
      fire && is_byte && in_frame_ff && length_taken_ff,
      rsp_valid_ff && rsp_data_ff.payload_valid)

endmodule

// ===== hdl/msp_matcher.sv =====
// Naive pattern matcher that drops back to its start on any mismatch.
module msp_matcher #(
   parameter int PAT_LEN = 4,
   parameter logic [8*PAT_LEN-1:0] PATTERN = '0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data,
   output logic       hit
);

   localparam int W = $clog2(PAT_LEN);

   logic [W-1:0] progress_ff;
   logic [W-1:0] progress_in;
   logic [7:0]   expected;
   logic         match;
   logic         last;

   // Character expected at the current position.
   assign expected = PATTERN[8*(PAT_LEN-1-int'(progress_ff)) +: 8];
   assign match    = (data == expected);
   assign last     = (progress_ff == W'(PAT_LEN-1));
   assign hit      = step & match & last;

   // Advance on a match, restart on completion or mismatch.
   always_comb begin
      progress_in = progress_ff;
      if (step) begin
         if (match && !last) begin
            progress_in = progress_ff + W'(1);
         end else begin
            progress_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff <= '0;
      end else begin
         progress_ff <= progress_in;
      end
   end

endmodule
